// ===== rtl/jcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// jcfp_pkg
// Shared widths, ranges and register codes of the joint command frame packer.
// ----------------------------------------------------------------------------
`default_nettype none

package jcfp_pkg;

  localparam int FIELD_W   = 18;
  localparam int FRAME_W   = 64;
  localparam int POS_BITS  = 16;
  localparam int CMD_BITS  = 12;
  localparam int CFG_IDX_W = 2;

  // ranges as multiples of one unit (span = K * 2^F)
  localparam int POS_SPAN_K = 25;
  localparam int VEL_SPAN_K = 90;
  localparam int KP_SPAN_K  = 500;
  localparam int KD_SPAN_K  = 5;
  localparam int TRQ_SPAN_K = 36;

  localparam int STOP_GAIN = 100;
  // torque plus overshoot term, full width
  localparam int TRQ_SUM_W = FIELD_W + 1 + $clog2(STOP_GAIN) + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_LIMIT = 2'd0,
    CFG_LOWER_LIMIT = 2'd1,
    CFG_ENABLE      = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== rtl/jcfp_quant.sv =====
// ----------------------------------------------------------------------------
// jcfp_quant
// Clamp a signed fixed point value to its range and scale it to an unsigned
// code: floor((x - lo) * (2^BITS - 1) / span), span = SPAN_K * 2^FRAC_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module jcfp_quant #(
  parameter int IN_W      = 18,
  parameter int FRAC_BITS = 8,
  parameter int SPAN_K    = 5,
  parameter bit SYMMETRIC = 1'b0,
  parameter int BITS      = 12
) (
  input  logic signed [IN_W-1:0] value_i,
  output logic        [BITS-1:0] code_o
);

  localparam int SPAN = SPAN_K << FRAC_BITS;
  localparam int LO   = SYMMETRIC ? -(SPAN / 2) : 0;
  localparam int HI   = LO + SPAN;
  localparam int SW   = $clog2(SPAN) + 2;
  localparam int W    = ((IN_W > SW) ? IN_W : SW) + 1;
  localparam int DW   = $clog2(SPAN + 1);
  localparam int MW   = $clog2(SPAN_K * ((1 << BITS) - 1) + 1);
  localparam int L    = $clog2(SPAN_K);
  localparam int S    = MW + L;
  localparam int RW   = S - L + 2;
  localparam int PW   = MW + RW;
  // rounded-up reciprocal, exact for every quotient of an MW bit dividend
  localparam longint RECIP = ((longint'(1) << S) + SPAN_K - 1) / SPAN_K;

  localparam logic signed [W-1:0] LO_W = W'(LO);
  localparam logic signed [W-1:0] HI_W = W'(HI);

  logic signed [W-1:0]    x_w;
  logic signed [W-1:0]    c_w;
  logic signed [W-1:0]    d_w;
  logic [DW-1:0]          d;
  logic [DW+BITS-1:0]     n;
  logic [MW-1:0]          m;
  logic [PW-1:0]          p;

  always_comb begin
    x_w = W'(value_i);
    if (x_w < LO_W) begin
      c_w = LO_W;
    end else if (x_w > HI_W) begin
      c_w = HI_W;
    end else begin
      c_w = x_w;
    end
    d_w = c_w - LO_W;
    d   = d_w[DW-1:0];
    // d * (2^BITS - 1), then drop the fraction: span carries 2^F
    n   = {d, BITS'(0)} - (DW+BITS)'(d);
    m   = n[FRAC_BITS+MW-1:FRAC_BITS];
    p   = PW'(m) * PW'(RECIP);
  end

  assign code_o = p[S+BITS-1:S];

endmodule

`default_nettype wire

// ===== rtl/joint_command_frame_packer.sv =====
// ----------------------------------------------------------------------------
// joint_command_frame_packer
// Soft stop override, clamping and quantisation of one joint command into an
// 8-byte motor command frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with the six command fields.
//   Output channel: out_valid_o / out_stall_i with command_frame_o (byte 0 in
//   bits 63..56) and softstop_hit_o.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 upper limit, 1 lower limit, 2 soft stop enable); other indexes are
//   ignored. Write only while no item is in flight.
//   An item passes an input register, then the override, clamp and
//   quantise logic, then the result register. One item per cycle is taken
//   while the receiver keeps up; the longest path is the reciprocal
//   multiply of the quantiser behind the torque overshoot sum.
//   When the receiver stalls, the result holds and one further item can still
//   enter the input register before in_stall_o rises.
//   Reset empties both registers and loads limits of +-1.5 and enables soft
//   stop.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_command_frame_packer
  import jcfp_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [FIELD_W-1:0]        cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] target_position_i,
  input  logic signed [FIELD_W-1:0] target_velocity_i,
  input  logic signed [FIELD_W-1:0] stiffness_gain_i,
  input  logic signed [FIELD_W-1:0] damping_gain_i,
  input  logic signed [FIELD_W-1:0] feedforward_torque_i,
  input  logic signed [FIELD_W-1:0] measured_position_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [FRAME_W-1:0]        command_frame_o,
  output logic                      softstop_hit_o
);

  localparam int ONE_Q        = 1 << FRACTION_BITS;
  localparam int KD_STOP      = (4 * ONE_Q + 5) / 10;
  localparam int LIMIT_RESET  = 3 << (FRACTION_BITS - 1);
  localparam int KD_STOP_CODE = (KD_STOP * ((1 << CMD_BITS) - 1)) / (KD_SPAN_K * ONE_Q);
  localparam int VEL_MID_CODE = ((1 << CMD_BITS) - 1) / 2;

  logic signed [FIELD_W-1:0] upper_q, lower_q;
  logic                      enable_q;

  logic                      s1_vld_q;
  logic signed [FIELD_W-1:0] pos_q, vel_q, kp_q, kd_q, trq_q, meas_q;

  logic                      out_vld_q;
  logic [FRAME_W-1:0]        frame_q, frame_d;
  logic                      hit_q, hit_d;

  logic                      out_en;
  logic                      in_acc;

  logic signed [FIELD_W-1:0]   lim;
  logic signed [FIELD_W:0]     overshoot;
  logic signed [TRQ_SUM_W-1:0] stop_term;
  logic signed [FIELD_W-1:0]   vel_sel, kp_sel, kd_sel;
  logic signed [TRQ_SUM_W-1:0] trq_sel;

  logic [POS_BITS-1:0] p_code;
  logic [CMD_BITS-1:0] v_code, kp_code, kd_code, t_code;

  assign out_en     = !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !out_en;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= FIELD_W'(LIMIT_RESET);
      lower_q  <= FIELD_W'(-LIMIT_RESET);
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_UPPER_LIMIT: upper_q  <= cfg_data_i;
        CFG_LOWER_LIMIT: lower_q  <= cfg_data_i;
        CFG_ENABLE:      enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_en) begin
        out_vld_q <= s1_vld_q;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (out_en) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q  <= target_position_i;
      vel_q  <= target_velocity_i;
      kp_q   <= stiffness_gain_i;
      kd_q   <= damping_gain_i;
      trq_q  <= feedforward_torque_i;
      meas_q <= measured_position_i;
    end
    if (out_en && s1_vld_q) begin
      frame_q <= frame_d;
      hit_q   <= hit_d;
    end
  end

  // soft stop: upper limit has priority
  always_comb begin
    hit_d = 1'b0;
    lim   = lower_q;
    if (enable_q) begin
      if (meas_q >= upper_q) begin
        hit_d = 1'b1;
        lim   = upper_q;
      end else if (meas_q <= lower_q) begin
        hit_d = 1'b1;
      end
    end
    overshoot = (FIELD_W+1)'(lim) - (FIELD_W+1)'(meas_q);
    stop_term = TRQ_SUM_W'(overshoot) * $signed(TRQ_SUM_W'(STOP_GAIN));
    if (hit_d) begin
      vel_sel = '0;
      kp_sel  = '0;
      kd_sel  = FIELD_W'(KD_STOP);
      trq_sel = TRQ_SUM_W'(trq_q) + stop_term;
    end else begin
      vel_sel = vel_q;
      kp_sel  = kp_q;
      kd_sel  = kd_q;
      trq_sel = TRQ_SUM_W'(trq_q);
    end
  end

  jcfp_quant #(
    .IN_W(FIELD_W), .FRAC_BITS(FRACTION_BITS), .SPAN_K(POS_SPAN_K),
    .SYMMETRIC(1'b1), .BITS(POS_BITS)
  ) u_pos (.value_i(pos_q), .code_o(p_code));

  jcfp_quant #(
    .IN_W(FIELD_W), .FRAC_BITS(FRACTION_BITS), .SPAN_K(VEL_SPAN_K),
    .SYMMETRIC(1'b1), .BITS(CMD_BITS)
  ) u_vel (.value_i(vel_sel), .code_o(v_code));

  jcfp_quant #(
    .IN_W(FIELD_W), .FRAC_BITS(FRACTION_BITS), .SPAN_K(KP_SPAN_K),
    .SYMMETRIC(1'b0), .BITS(CMD_BITS)
  ) u_kp (.value_i(kp_sel), .code_o(kp_code));

  jcfp_quant #(
    .IN_W(FIELD_W), .FRAC_BITS(FRACTION_BITS), .SPAN_K(KD_SPAN_K),
    .SYMMETRIC(1'b0), .BITS(CMD_BITS)
  ) u_kd (.value_i(kd_sel), .code_o(kd_code));

  jcfp_quant #(
    .IN_W(TRQ_SUM_W), .FRAC_BITS(FRACTION_BITS), .SPAN_K(TRQ_SPAN_K),
    .SYMMETRIC(1'b1), .BITS(CMD_BITS)
  ) u_trq (.value_i(trq_sel), .code_o(t_code));

  assign frame_d = {p_code, v_code, kp_code, kd_code, t_code};

  assign out_valid_o     = out_vld_q;
  assign command_frame_o = frame_q;
  assign softstop_hit_o  = hit_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && out_vld_q)
    else $error("input stalled without a held item");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !out_en |=> s1_vld_q)
    else $error("held item dropped while output stalled");

  a_stop_gains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && hit_q |-> command_frame_o[35:24] == '0 &&
      command_frame_o[47:36] == CMD_BITS'(VEL_MID_CODE))
    else $error("soft stop item with non-zero velocity or kp");

  a_stop_kd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && hit_q |-> command_frame_o[23:12] == CMD_BITS'(KD_STOP_CODE))
    else $error("soft stop item with wrong kd code");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the joint command frame packer against a predictor of the soft stop
// override, clamp and quantise steps. A short table of commands comes first,
// some with hand-worked frames. Random commands follow under several limit and
// enable settings, with bursty input, receiver back-pressure, one long
// receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------

module tb_top
  import jcfp_pkg::*;
();

  localparam int     FRAC_BITS     = 8;
  localparam longint ONE_Q         = longint'(1) << FRAC_BITS;
  localparam longint POS_MAX       = POS_SPAN_K * ONE_Q / 2;
  localparam longint VEL_MAX       = VEL_SPAN_K * ONE_Q / 2;
  localparam longint KP_MAX        = KP_SPAN_K * ONE_Q;
  localparam longint KD_MAX        = KD_SPAN_K * ONE_Q;
  localparam longint TRQ_MAX       = TRQ_SPAN_K * ONE_Q / 2;
  localparam longint KD_STOP       = (4 * ONE_Q + 5) / 10;
  localparam int     PHASE_ITEMS   = 248;
  localparam int     HOLD_CYCLES   = 80;
  localparam int     WATCHDOG_MAX  = 2000;
  localparam int     DIRECTED_ROWS = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos;
    logic signed [FIELD_W-1:0] vel;
    logic signed [FIELD_W-1:0] kp;
    logic signed [FIELD_W-1:0] kd;
    logic signed [FIELD_W-1:0] trq;
    logic signed [FIELD_W-1:0] meas;
  } cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               hit;
  } frame_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               typed;
    logic [FRAME_W-1:0] frame;
    logic               hit;
  } dir_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [FIELD_W-1:0]        cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [FIELD_W-1:0] target_position_i;
  logic signed [FIELD_W-1:0] target_velocity_i;
  logic signed [FIELD_W-1:0] stiffness_gain_i;
  logic signed [FIELD_W-1:0] damping_gain_i;
  logic signed [FIELD_W-1:0] feedforward_torque_i;
  logic signed [FIELD_W-1:0] measured_position_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [FRAME_W-1:0]        command_frame_o;
  logic                      softstop_hit_o;

  // model copy of the registers
  longint upper_lim = 384;
  longint lower_lim = -384;
  bit     stop_en   = 1'b1;

  frame_t frames_due[$];
  int     error_count = 0;
  int     idle_count  = 0;
  bit     hold_req    = 1'b0;

  // hand-worked frame for the item on the port, when set
  logic               typed_item  = 1'b0;
  logic [FRAME_W-1:0] typed_frame = '0;
  logic               typed_hit   = 1'b0;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{-131072, -131072, -131072, -131072, -131072, 0}, 1'b1, 64'h0, 1'b0},
    '{'{131071, 131071, 131071, 131071, 131071, 0}, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{'{0, 131071, 131071, 0, 0, 384}, 1'b1, 64'h7FFF_7FF0_0014_67FF, 1'b1},
    '{'{0, -131072, -5, 131071, 0, -384}, 1'b1, 64'h7FFF_7FF0_0014_67FF, 1'b1},
    '{'{100, 200, 300, 400, 500, 383}, 1'b0, 64'h0, 1'b0},
    '{'{-100, -200, -300, -400, -500, -383}, 1'b0, 64'h0, 1'b0},
    '{'{0, 5, 5, 5, 131071, 131071}, 1'b1, 64'h7FFF_7FF0_0014_6000, 1'b1},
    '{'{0, 5, 5, 5, -131072, -131072}, 1'b1, 64'h7FFF_7FF0_0014_6FFF, 1'b1},
    '{'{1000, -1000, 1000, 100, 0, 390}, 1'b0, 64'h0, 1'b0},
    '{'{3200, 11520, 128000, 1280, 4608, 0}, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{'{-3200, -11520, 0, 0, -4608, 0}, 1'b1, 64'h0, 1'b0},
    '{'{3201, -11521, -1, -1, 4609, -1}, 1'b0, 64'h0, 1'b0},
    '{'{18'h2AAAA, 18'h2AAAA, 18'h2AAAA, 18'h2AAAA, 18'h2AAAA, 18'h2AAAA},
      1'b0, 64'h0, 1'b0},
    '{'{18'h15555, 18'h15555, 18'h15555, 18'h15555, 18'h15555, 18'h15555},
      1'b0, 64'h0, 1'b0}
  };

  joint_command_frame_packer #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .target_position_i   (target_position_i),
    .target_velocity_i   (target_velocity_i),
    .stiffness_gain_i    (stiffness_gain_i),
    .damping_gain_i      (damping_gain_i),
    .feedforward_torque_i(feedforward_torque_i),
    .measured_position_i (measured_position_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .command_frame_o     (command_frame_o),
    .softstop_hit_o      (softstop_hit_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint quantise(longint x, longint lo, longint hi, int bits);
    longint c;
    c = (x < lo) ? lo : ((x > hi) ? hi : x);
    return ((c - lo) * ((longint'(1) << bits) - 1)) / (hi - lo);
  endfunction

  function automatic frame_t pack_command(cmd_t c);
    frame_t                r;
    longint                vel, kp, kd, trq, meas, lim;
    bit                    hit;
    logic [POS_BITS-1:0]   p_code;
    logic [CMD_BITS-1:0]   v_code, kp_code, kd_code, t_code;
    vel  = $signed(c.vel);
    kp   = $signed(c.kp);
    kd   = $signed(c.kd);
    trq  = $signed(c.trq);
    meas = $signed(c.meas);
    hit  = 1'b0;
    lim  = 0;
    // upper limit wins when the limits cross
    if (stop_en) begin
      if (meas >= upper_lim) begin
        hit = 1'b1;
        lim = upper_lim;
      end else if (meas <= lower_lim) begin
        hit = 1'b1;
        lim = lower_lim;
      end
    end
    if (hit) begin
      vel = 0;
      kp  = 0;
      kd  = KD_STOP;
      trq = trq + STOP_GAIN * (lim - meas);
    end
    p_code  = POS_BITS'(quantise($signed(c.pos), -POS_MAX, POS_MAX, POS_BITS));
    v_code  = CMD_BITS'(quantise(vel, -VEL_MAX, VEL_MAX, CMD_BITS));
    kp_code = CMD_BITS'(quantise(kp, 0, KP_MAX, CMD_BITS));
    kd_code = CMD_BITS'(quantise(kd, 0, KD_MAX, CMD_BITS));
    t_code  = CMD_BITS'(quantise(trq, -TRQ_MAX, TRQ_MAX, CMD_BITS));
    r.frame = {p_code, v_code, kp_code, kd_code, t_code};
    r.hit   = hit;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_field(longint bound);
    int r;
    r = $urandom_range(0, 9);
    if (r <= 3) return FIELD_W'($urandom);
    if (r <= 7) return FIELD_W'($urandom_range(0, 32'(2 * bound + 32)) - bound - 16);
    if (r == 8) return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
    case ($urandom_range(0, 2))
      0:       return FIELD_W'(bound);
      1:       return FIELD_W'(-bound);
      default: return '0;
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_meas();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 2) return FIELD_W'($urandom);
    if (r <= 5) return FIELD_W'(upper_lim + $urandom_range(0, 16) - 8);
    if (r <= 8) return FIELD_W'(lower_lim + $urandom_range(0, 16) - 8);
    return pick_field(600);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(cmd_t c, logic typed, logic [FRAME_W-1:0] frame, logic hit);
    target_position_i    = c.pos;
    target_velocity_i    = c.vel;
    stiffness_gain_i     = c.kp;
    damping_gain_i       = c.kd;
    feedforward_torque_i = c.trq;
    measured_position_i  = c.meas;
    typed_item           = typed;
    typed_frame          = frame;
    typed_hit            = hit;
    in_valid_i           = 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (frames_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      CFG_UPPER_LIMIT: upper_lim = $signed(data);
      CFG_LOWER_LIMIT: lower_lim = $signed(data);
      CFG_ENABLE:      stop_en   = data[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(int n_items, bit gaps, bit hold, bit pause_mid);
    int   burst;
    cmd_t c;
    burst = 0;
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (pause_mid && i == n_items / 2) begin
        in_valid_i = 1'b0;
        do @(negedge clk_i); while (frames_due.size() != 0);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (gaps && $urandom_range(0, 1)) begin
          in_valid_i = 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk_i);
        end
      end
      burst--;
      c.pos  = pick_field(POS_MAX);
      c.vel  = pick_field(VEL_MAX);
      c.kp   = pick_field(KP_MAX);
      c.kd   = pick_field(KD_MAX);
      c.trq  = pick_field(TRQ_MAX);
      c.meas = pick_meas();
      send_item(c, 1'b0, '0, 1'b0);
    end
  endtask

  // receiver back-pressure
  initial begin : receiver
    int seg_len;
    int mode;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_stall_i = 1'b1;
        end
        hold_req = 1'b0;
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(1, 40);
        repeat (seg_len) begin
          @(negedge clk_i);
          case (mode)
            0:       out_stall_i = 1'b0;
            1:       out_stall_i = ($urandom_range(0, 3) == 0);
            2:       out_stall_i = 1'($urandom_range(0, 1));
            default: out_stall_i = ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    frame_t exp_r;
    frame_t cur;
    bit     moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (frames_due.size() == 0) begin
          $error("unexpected item: command_frame %h softstop_hit %b",
                 command_frame_o, softstop_hit_o);
          error_count++;
        end else begin
          exp_r = frames_due.pop_front();
          if (command_frame_o !== exp_r.frame) begin
            $error("command_frame: expected %h, got %h", exp_r.frame, command_frame_o);
            error_count++;
          end
          if (softstop_hit_o !== exp_r.hit) begin
            $error("softstop_hit: expected %b, got %b", exp_r.hit, softstop_hit_o);
            error_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        if (typed_item) begin
          cur.frame = typed_frame;
          cur.hit   = typed_hit;
        end else begin
          cur = pack_command('{target_position_i, target_velocity_i, stiffness_gain_i,
                               damping_gain_i, feedforward_torque_i,
                               measured_position_i});
        end
        frames_due.push_back(cur);
      end
    end
    idle_count = moved ? 0 : idle_count + 1;
  end

  initial begin : watchdog
    while (idle_count < WATCHDOG_MAX) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_UPPER_LIMIT;
    cfg_data_i           = '0;
    in_valid_i           = 1'b0;
    target_position_i    = '0;
    target_velocity_i    = '0;
    stiffness_gain_i     = '0;
    damping_gain_i       = '0;
    feedforward_torque_i = '0;
    measured_position_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_item(directed_rows[i].cmd, directed_rows[i].typed,
                directed_rows[i].frame, directed_rows[i].hit);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0, 1'b0);

    drain();
    cfg_write(CFG_UPPER_LIMIT, 18'h1FFFF);
    cfg_write(CFG_LOWER_LIMIT, 18'h20000);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);

    // crossed at the extremes: every item takes the upper branch
    drain();
    cfg_write(CFG_UPPER_LIMIT, 18'h20000);
    cfg_write(CFG_LOWER_LIMIT, 18'h1FFFF);
    run_phase(PHASE_ITEMS, 1'b0, 1'b1, 1'b0);

    drain();
    cfg_write(CFG_UPPER_LIMIT, FIELD_W'(-500));
    cfg_write(CFG_LOWER_LIMIT, FIELD_W'(500));
    run_phase(PHASE_ITEMS, 1'b1, 1'b0, 1'b0);

    drain();
    cfg_write(CFG_ENABLE, 18'h3FFFE);
    cfg_write(CFG_UPPER_LIMIT, '0);
    cfg_write(CFG_LOWER_LIMIT, '0);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0, 1'b1);

    drain();
    cfg_write(CFG_ENABLE, 18'h00001);
    cfg_write(CFG_UNUSED, 18'h3FFFF);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0, 1'b0);

    drain();
    cfg_write(CFG_UPPER_LIMIT, FIELD_W'($urandom_range(0, 3000)));
    cfg_write(CFG_LOWER_LIMIT, FIELD_W'(-$urandom_range(0, 3000)));
    cfg_write(CFG_ENABLE, FIELD_W'({$urandom, 1'b1}));
    cfg_write(CFG_UNUSED, FIELD_W'($urandom));
    run_phase(PHASE_ITEMS, 1'b1, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && frames_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
